/* hw/rtl/stx_pkg.sv */
package stx_pkg;

  // Frame format
  localparam int unsigned MaxPayload = 60;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = 7;
  localparam int unsigned PlenW      = 6;
  localparam int unsigned PcW        = 2;

  localparam logic [7:0] StartMark = 8'h02;
  localparam logic [7:0] EndMark   = 8'h03;

  // Status codes reported in the status word
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadStart = 3'd1,
    StLen      = 3'd2,
    StChk      = 3'd3,
    StOvf      = 3'd4
  } status_e;

  // Microcode: condition that lets a step advance
  typedef enum logic [1:0] {
    AdvAlways  = 2'd0,
    AdvClose   = 2'd1,
    AdvOutFree = 2'd2
  } adv_e;

  // Microcode: condition that selects the jump target
  typedef enum logic [1:0] {
    JmpNever    = 2'd0,
    JmpPlenZero = 2'd1,
    JmpMore     = 2'd2
  } jmp_e;

  // Microcode addresses
  localparam logic [PcW-1:0] PcIdle   = 2'd0;
  localparam logic [PcW-1:0] PcStatus = 2'd1;
  localparam logic [PcW-1:0] PcRead   = 2'd2;
  localparam logic [PcW-1:0] PcEmit   = 2'd3;

  // Datapath controls driven by the current control word
  typedef struct packed {
    logic accept;
    logic emit_sts;
    logic rd_req;
    logic emit_body;
  } ctl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic close_acc;
    logic out_free;
    logic plen_zero;
    logic more;
  } flags_t;

  typedef struct packed {
    ctl_t            ctl;
    adv_e            adv;
    jmp_e            jmp;
    logic [PcW-1:0]  jmp_tgt;
    logic [PcW-1:0]  seq_tgt;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t uc;
    uc = '0;
    unique case (pc)
      // collect bytes until the end mark
      PcIdle: begin
        uc.ctl.accept = 1'b1;
        uc.adv        = AdvClose;
        uc.jmp        = JmpNever;
        uc.jmp_tgt    = PcIdle;
        uc.seq_tgt    = PcStatus;
      end
      // send the status word; done if no payload
      PcStatus: begin
        uc.ctl.emit_sts = 1'b1;
        uc.adv          = AdvOutFree;
        uc.jmp          = JmpPlenZero;
        uc.jmp_tgt      = PcIdle;
        uc.seq_tgt      = PcRead;
      end
      // fetch the next payload byte
      PcRead: begin
        uc.ctl.rd_req = 1'b1;
        uc.adv        = AdvAlways;
        uc.jmp        = JmpNever;
        uc.jmp_tgt    = PcRead;
        uc.seq_tgt    = PcEmit;
      end
      // send it; loop while bytes remain
      PcEmit: begin
        uc.ctl.emit_body = 1'b1;
        uc.adv           = AdvOutFree;
        uc.jmp           = JmpMore;
        uc.jmp_tgt       = PcRead;
        uc.seq_tgt       = PcIdle;
      end
      default: uc = '0;
    endcase
    return uc;
  endfunction

endpackage

/* hw/rtl/stx_ram.sv */
module stx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/stx_useq.sv */
module stx_useq import stx_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctl_t   ctl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uc;
  logic           adv;
  logic           jmp;

  assign uc    = ucode_rom(pc_q);
  assign ctl_o = uc.ctl;

  // Evaluate advance and jump conditions
  always_comb begin
    unique case (uc.adv)
      AdvAlways:  adv = 1'b1;
      AdvClose:   adv = flags_i.close_acc;
      AdvOutFree: adv = flags_i.out_free;
      default:    adv = 1'b0;
    endcase
    unique case (uc.jmp)
      JmpNever:    jmp = 1'b0;
      JmpPlenZero: jmp = flags_i.plen_zero;
      JmpMore:     jmp = flags_i.more;
      default:     jmp = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    pc_d = pc_q;
    if (adv) begin
      pc_d = jmp ? uc.jmp_tgt : uc.seq_tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/stx_dp.sv */
module stx_dp import stx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  output flags_t           flags_o,
  input  logic             in_valid_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             is_status_o,
  output logic [2:0]       status_o,
  output logic [PlenW-1:0] payload_length_o,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  localparam logic [CntW-1:0] CntLimit = CntW'(MaxPayload + 3);

  // Frame state
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       start_q, start_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       xor_q, xor_d;
  logic             ovf_q, ovf_d;
  // Closed-frame result and body index
  status_e          sts_q, sts_d;
  logic [PlenW-1:0] plen_q, plen_d;
  logic [AddrW-1:0] idx_q, idx_d;
  // Output word register
  logic             ovld_q, ovld_d;
  logic             oiss_q, oiss_d;
  logic [2:0]       osts_q, osts_d;
  logic [PlenW-1:0] oplen_q, oplen_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;

  logic             acc;
  logic             close_acc;
  logic             data_acc;
  logic             out_free;
  logic             load_sts;
  logic             load_body;
  logic             more;
  logic             wr_en;
  logic [CntW-1:0]  wr_off;
  logic [7:0]       rd_data;
  status_e          sts_calc;
  logic [PlenW-1:0] plen_calc;

  assign acc       = in_valid_i && ctl_i.accept;
  assign close_acc = acc && (rx_byte_i == EndMark);
  assign data_acc  = acc && (rx_byte_i != EndMark);
  assign out_free  = !ovld_q || !out_stall_i;
  assign load_sts  = ctl_i.emit_sts && out_free;
  assign load_body = ctl_i.emit_body && out_free;
  assign more      = ({1'b0, idx_q} + (AddrW + 1)'(1)) != (AddrW + 1)'(plen_q);

  assign flags_o.close_acc = close_acc;
  assign flags_o.out_free  = out_free;
  assign flags_o.plen_zero = (plen_q == '0);
  assign flags_o.more      = more;

  // Body store write: frame byte i+2 goes to entry i
  assign wr_off = cnt_q - CntW'(2);
  assign wr_en  = data_acc && (cnt_q < CntLimit) && (cnt_q >= CntW'(2));

  stx_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_body (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_off[AddrW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (ctl_i.rd_req),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Check the frame in decode order
  always_comb begin
    plen_calc = '0;
    priority if (ovf_q) begin
      sts_calc = StOvf;
    end else if (cnt_q == '0 || start_q != StartMark) begin
      sts_calc = StBadStart;
    end else if (cnt_q < CntW'(2) ||
                 ({1'b0, len_q} + 9'd4) != (9'(cnt_q) + 9'd1)) begin
      sts_calc = StLen;
    end else if (xor_q != '0) begin
      sts_calc = StChk;
    end else begin
      sts_calc  = StOk;
      plen_calc = len_q[PlenW-1:0];
    end
  end

  // Collect bytes; clear the frame on close; step the body index per payload load
  always_comb begin
    cnt_d   = cnt_q;
    start_d = start_q;
    len_d   = len_q;
    xor_d   = xor_q;
    ovf_d   = ovf_q;
    sts_d   = sts_q;
    plen_d  = plen_q;
    idx_d   = idx_q;
    if (close_acc) begin
      sts_d   = sts_calc;
      plen_d  = plen_calc;
      idx_d   = '0;
      cnt_d   = '0;
      start_d = '0;
      len_d   = '0;
      xor_d   = '0;
      ovf_d   = 1'b0;
    end else if (data_acc) begin
      if (cnt_q >= CntLimit) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q == '0) begin
          start_d = rx_byte_i;
        end else if (cnt_q == CntW'(1)) begin
          len_d = rx_byte_i;
        end else begin
          xor_d = xor_q ^ rx_byte_i;
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end
    if (load_body) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  // Output word register
  always_comb begin
    ovld_d  = ovld_q;
    oiss_d  = oiss_q;
    osts_d  = osts_q;
    oplen_d = oplen_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (load_sts) begin
      ovld_d  = 1'b1;
      oiss_d  = 1'b1;
      osts_d  = sts_q;
      oplen_d = plen_q;
      obyte_d = '0;
      olast_d = (plen_q == '0);
    end else if (load_body) begin
      ovld_d  = 1'b1;
      oiss_d  = 1'b0;
      osts_d  = StOk;
      oplen_d = plen_q;
      obyte_d = rd_data;
      olast_d = !more;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      xor_q   <= '0;
      ovf_q   <= 1'b0;
      sts_q   <= StOk;
      plen_q  <= '0;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      start_q <= start_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      ovf_q   <= ovf_d;
      sts_q   <= sts_d;
      plen_q  <= plen_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oiss_q  <= oiss_d;
    osts_q  <= osts_d;
    oplen_q <= oplen_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o      = ovld_q;
  assign is_status_o      = oiss_q;
  assign status_o         = osts_q;
  assign payload_length_o = oplen_q;
  assign out_byte_o       = obyte_q;
  assign last_o           = olast_q;

endmodule

/* hw/rtl/stx_etx_frame_receiver.sv */
// Input: one byte per cycle while a frame is being collected.
// The end mark latches the result; the status step then loads the status word
// once the output is free. Each payload word takes a body store read step, then
// an output load; the input stalls from the end mark until the last word loads.
// Reset clears the sequencer, frame state and output valid; the body store
// is not cleared, and no step reads an entry not written in the same frame.
module stx_etx_frame_receiver import stx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_status_o,
  output logic [2:0]       status_o,
  output logic [PlenW-1:0] payload_length_o,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  ctl_t   ctl;
  flags_t flags;

  stx_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  stx_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .flags_o          (flags),
    .in_valid_i       (in_valid_i),
    .rx_byte_i        (rx_byte_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .is_status_o      (is_status_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o)
  );

  // Take input only in the collect step
  assign in_stall_o = !ctl.accept;

  // Input blocks right after a frame closes
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.close_acc |=> in_stall_o)
    else $error("input not stalled after frame close");

  // A status word with payload behind it is never last
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_status_o && payload_length_o != '0) |-> !last_o)
    else $error("status word marked last ahead of payload");

  // Payload words belong to a good, non-empty frame
  a_body_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_status_o) |-> (status_o == StOk && payload_length_o != '0))
    else $error("payload word outside a good frame");

endmodule
